### src/wcf_pkg.sv
// ----------------------------------------------------------------------------
// wcf_pkg
// Shared widths, codes and record types of the wrench change filter.
// ----------------------------------------------------------------------------
package wcf_pkg;

  // Field widths.
  localparam int unsigned FRAME_W    = 4;
  localparam int unsigned SEC_W      = 32;
  localparam int unsigned NSEC_W     = 30;
  localparam int unsigned COMP_W     = 32;
  localparam int unsigned WINDOW_W   = 48;
  localparam int unsigned LIMIT_W    = 32;
  localparam int unsigned MASK_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned DEC_W      = 3;

  // Derived arithmetic widths. A timestamp in nanoseconds stays below 2^62,
  // a component magnitude below 2^32, its square below 2^64.
  localparam int unsigned STAMP_W  = 62;
  localparam int unsigned MAG_W    = 32;
  localparam int unsigned SQ_W     = 64;
  localparam int unsigned SUM_W    = 66;
  localparam int unsigned LIMSQ_W  = 64;

  localparam logic [NSEC_W-1:0]  NS_PER_SEC  = 30'd1_000_000_000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd66;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_WINDOW  = 2'd0,
    CFG_FORCE_LIMIT  = 2'd1,
    CFG_TORQUE_LIMIT = 2'd2,
    CFG_MANAGED_MASK = 2'd3
  } cfg_idx_e;

  // Judgement codes.
  typedef enum logic [DEC_W-1:0] {
    DEC_NEW_FRAME = 3'd0,
    DEC_MANAGED   = 3'd1,
    DEC_TIMEOUT   = 3'd2,
    DEC_FORCE     = 3'd3,
    DEC_TORQUE    = 3'd4,
    DEC_UNCHANGED = 3'd5
  } decision_e;

  // One stored sample; lane 0 is x, lane 2 is z.
  typedef struct packed {
    logic [STAMP_W-1:0]         stamp;
    logic [2:0][COMP_W-1:0]     force_vec;
    logic [2:0][COMP_W-1:0]     torque_vec;
  } sample_t;

  // Per-item control that travels down the pipeline.
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               in_range;
    logic               managed;
    logic               known;
  } item_ctl_t;

  // One judged result.
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    decision_e          decision;
    logic               log_sample;
    logic               mem_upd;
  } result_t;

endpackage

### src/wrench_change_filter.sv
// ----------------------------------------------------------------------------
// wrench_change_filter
// Send-on-delta filter for timestamped force/torque samples, one judgement
// per sample, with the last kept sample of each frame in a local store.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle unless stalled and returns its
// judgement through the delta stage register, the decide stage register and
// the output register. A frame's stored sample is read from a synchronous
// memory and rewritten by the decide stage; a sample of the same frame as the
// sample directly ahead of it therefore waits in the delta stage until that
// write has landed, so the input stalls behind such a pair. Samples of other
// frames flow back to back. Frame valid flags are flip-flops cleared by reset,
// so the block is ready right after reset with no clearing pass.
// ----------------------------------------------------------------------------
module wrench_change_filter #(
  parameter int unsigned FRAMES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [wcf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wcf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Sample input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [wcf_pkg::FRAME_W-1:0]        frame_i,
  input  logic [wcf_pkg::SEC_W-1:0]          stamp_sec_i,
  input  logic [wcf_pkg::NSEC_W-1:0]         stamp_nsec_i,
  input  logic signed [wcf_pkg::COMP_W-1:0]  force_x_i,
  input  logic signed [wcf_pkg::COMP_W-1:0]  force_y_i,
  input  logic signed [wcf_pkg::COMP_W-1:0]  force_z_i,
  input  logic signed [wcf_pkg::COMP_W-1:0]  torque_x_i,
  input  logic signed [wcf_pkg::COMP_W-1:0]  torque_y_i,
  input  logic signed [wcf_pkg::COMP_W-1:0]  torque_z_i,
  // Result output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [wcf_pkg::FRAME_W-1:0]        frame_out_o,
  output logic [wcf_pkg::DEC_W-1:0]          decision_o,
  output logic                               log_sample_o,
  output logic                               memory_updated_o
);

  localparam int unsigned AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  // Configuration registers and derived squared limits.
  logic [wcf_pkg::WINDOW_W-1:0] time_window_q;
  logic [wcf_pkg::LIMIT_W-1:0]  force_limit_q;
  logic [wcf_pkg::LIMIT_W-1:0]  torque_limit_q;
  logic [wcf_pkg::MASK_W-1:0]   managed_mask_q;
  logic [wcf_pkg::LIMSQ_W-1:0]  force_lim_sq_q;
  logic [wcf_pkg::LIMSQ_W-1:0]  torque_lim_sq_q;

  // Pipeline control.
  logic accept;
  logic out_free;
  logic s2_adv;
  logic s2_free;
  logic s1_block;
  logic s1_adv;
  logic s1_free;
  logic s1_valid_q;
  logic s2_valid_q;
  logic out_valid_q;

  // Stage contents.
  wcf_pkg::sample_t   s1_smp_d;
  wcf_pkg::sample_t   s1_smp_q;
  wcf_pkg::item_ctl_t s1_ctl_d;
  wcf_pkg::item_ctl_t s1_ctl_q;
  wcf_pkg::item_ctl_t s1_ctl;
  wcf_pkg::sample_t   last_smp;
  logic               last_known;
  wcf_pkg::item_ctl_t s2_ctl;
  wcf_pkg::sample_t   s2_smp;
  logic               s2_timeout;
  logic [2:0][wcf_pkg::SQ_W-1:0] s2_force_sq;
  logic [2:0][wcf_pkg::SQ_W-1:0] s2_torque_sq;
  logic               s2_upd;
  logic               wr_en;
  wcf_pkg::result_t   res;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_window_q  <= '0;
      force_limit_q  <= wcf_pkg::LIMIT_RESET;
      torque_limit_q <= wcf_pkg::LIMIT_RESET;
      managed_mask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (wcf_pkg::cfg_idx_e'(cfg_idx_i))
        wcf_pkg::CFG_TIME_WINDOW:  time_window_q  <= cfg_data_i;
        wcf_pkg::CFG_FORCE_LIMIT:  force_limit_q  <= cfg_data_i[wcf_pkg::LIMIT_W-1:0];
        wcf_pkg::CFG_TORQUE_LIMIT: torque_limit_q <= cfg_data_i[wcf_pkg::LIMIT_W-1:0];
        wcf_pkg::CFG_MANAGED_MASK: managed_mask_q <= cfg_data_i[wcf_pkg::MASK_W-1:0];
      endcase
    end
  end

  // Squared thresholds, registered off the limit registers.
  always_ff @(posedge clk_i) begin
    force_lim_sq_q  <= wcf_pkg::LIMSQ_W'(force_limit_q) * wcf_pkg::LIMSQ_W'(force_limit_q);
    torque_lim_sq_q <= wcf_pkg::LIMSQ_W'(torque_limit_q) * wcf_pkg::LIMSQ_W'(torque_limit_q);
  end

  // Flow control. The delta stage holds while the decide stage carries a
  // sample of the same frame, so it always compares against the newest copy.
  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    s2_adv     = s2_valid_q && out_free;
    s2_free    = !s2_valid_q || out_free;
    s1_block   = s2_valid_q && (s2_ctl.frame == s1_ctl_q.frame);
    s1_adv     = s1_valid_q && s2_free && !s1_block;
    s1_free    = !s1_valid_q || s1_adv;
    in_stall_o = !s1_free;
    accept     = in_valid_i && s1_free;
  end

  // Incoming sample, with its timestamp folded into nanoseconds.
  always_comb begin
    s1_smp_d.stamp = wcf_pkg::STAMP_W'(stamp_sec_i) * wcf_pkg::STAMP_W'(wcf_pkg::NS_PER_SEC) +
                     wcf_pkg::STAMP_W'(stamp_nsec_i);
    s1_smp_d.force_vec[0]  = force_x_i;
    s1_smp_d.force_vec[1]  = force_y_i;
    s1_smp_d.force_vec[2]  = force_z_i;
    s1_smp_d.torque_vec[0] = torque_x_i;
    s1_smp_d.torque_vec[1] = torque_y_i;
    s1_smp_d.torque_vec[2] = torque_z_i;

    s1_ctl_d.frame    = frame_i;
    s1_ctl_d.in_range = (32'(frame_i) < FRAMES);
    s1_ctl_d.managed  = managed_mask_q[frame_i];
    s1_ctl_d.known    = 1'b0;
  end

  // Delta stage register, loaded on each input transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_smp_q <= s1_smp_d;
      s1_ctl_q <= s1_ctl_d;
    end
  end

  // Stage occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= accept;
      end
      if (s2_free) begin
        s2_valid_q <= s1_adv;
      end
      if (out_free) begin
        out_valid_q <= s2_adv;
      end
    end
  end

  // Stored sample per frame.
  wcf_sample_ram #(
    .FRAMES (FRAMES),
    .AW     (AW)
  ) u_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (AW'(frame_i)),
    .wr_en_i    (wr_en),
    .wr_addr_i  (AW'(s2_ctl.frame)),
    .wr_data_i  (s2_smp),
    .rd_data_o  (last_smp),
    .rd_valid_o (last_known)
  );

  always_comb begin
    s1_ctl       = s1_ctl_q;
    s1_ctl.known = last_known;
  end

  // Time and distance checks.
  wcf_delta_stage u_delta (
    .clk_i       (clk_i),
    .load_i      (s1_adv),
    .ctl_i       (s1_ctl),
    .cur_i       (s1_smp_q),
    .last_i      (last_smp),
    .window_i    (time_window_q),
    .ctl_o       (s2_ctl),
    .cur_o       (s2_smp),
    .timeout_o   (s2_timeout),
    .force_sq_o  (s2_force_sq),
    .torque_sq_o (s2_torque_sq)
  );

  // Judgement and result register.
  wcf_decide u_decide (
    .clk_i           (clk_i),
    .load_i          (s2_adv),
    .ctl_i           (s2_ctl),
    .timeout_i       (s2_timeout),
    .force_sq_i      (s2_force_sq),
    .torque_sq_i     (s2_torque_sq),
    .force_lim_sq_i  (force_lim_sq_q),
    .torque_lim_sq_i (torque_lim_sq_q),
    .upd_o           (s2_upd),
    .res_o           (res)
  );

  // The store is rewritten when a kept sample of an in-range, unmanaged frame leaves the decide stage.
  assign wr_en = s2_adv && s2_upd;

  assign out_valid_o      = out_valid_q;
  assign frame_out_o      = res.frame;
  assign decision_o       = res.decision;
  assign log_sample_o     = res.log_sample;
  assign memory_updated_o = res.mem_upd;

  // An empty delta stage never holds off the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty delta stage");

  // Only a kept sample can replace the stored one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && memory_updated_o) |-> log_sample_o)
    else $error("store updated for a dropped sample");

  // A store write is reported on the result of the same sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (out_valid_o && memory_updated_o))
    else $error("store write without a matching result");

endmodule

### src/wcf_sample_ram.sv
// ----------------------------------------------------------------------------
// wcf_sample_ram
// Per-frame sample store: one write port, one registered read port with
// write-first bypass, and reset-cleared valid flags in flip-flops.
// ----------------------------------------------------------------------------
module wcf_sample_ram #(
  parameter int unsigned FRAMES = 16,
  parameter int unsigned AW     = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  wcf_pkg::sample_t  wr_data_i,
  output wcf_pkg::sample_t  rd_data_o,
  output logic              rd_valid_o
);

  wcf_pkg::sample_t mem_q [FRAMES];
  logic [FRAMES-1:0] valid_q;
  wcf_pkg::sample_t  rd_data_q;
  logic              rd_valid_q;
  logic [AW-1:0]     cur_addr_q;
  logic              hit_rd;
  logic              hit_cur;

  // A write to the address being read, or to the address whose data is
  // still held, must show up in the read register.
  assign hit_rd  = wr_en_i && (wr_addr_i == rd_addr_i);
  assign hit_cur = wr_en_i && (wr_addr_i == cur_addr_q);

  // Sample array.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Valid flags, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Registered read data, refreshed when the held entry is rewritten.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      cur_addr_q <= rd_addr_i;
      if (hit_rd) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end else if (hit_cur) begin
      rd_data_q <= wr_data_i;
    end
  end

  // Registered valid flag, with the same bypass and refresh.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_valid_q <= hit_rd || valid_q[rd_addr_i];
    end else if (hit_cur) begin
      rd_valid_q <= 1'b1;
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

  // A read that meets a write to the same entry returns the written sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_i && hit_rd) |=> (rd_data_q == $past(wr_data_i)) && rd_valid_q)
    else $error("read bypass missed a same-entry write");

  // A write to the held entry marks the held data valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!rd_en_i && hit_cur) |=> rd_valid_q)
    else $error("held read data not refreshed after a write");

  // A write to the held entry replaces the held data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!rd_en_i && hit_cur) |=> (rd_data_q == $past(wr_data_i)))
    else $error("held read data missed a write to its entry");

endmodule

### src/wcf_delta_stage.sv
// ----------------------------------------------------------------------------
// wcf_delta_stage
// Compares a sample with its frame's stored sample: time step against the
// window, and the squared change of each force and torque component.
// ----------------------------------------------------------------------------
module wcf_delta_stage (
  input  logic                                      clk_i,
  input  logic                                      load_i,
  input  wcf_pkg::item_ctl_t                        ctl_i,
  input  wcf_pkg::sample_t                          cur_i,
  input  wcf_pkg::sample_t                          last_i,
  input  logic [wcf_pkg::WINDOW_W-1:0]              window_i,
  output wcf_pkg::item_ctl_t                        ctl_o,
  output wcf_pkg::sample_t                          cur_o,
  output logic                                      timeout_o,
  output logic [2:0][wcf_pkg::SQ_W-1:0]             force_sq_o,
  output logic [2:0][wcf_pkg::SQ_W-1:0]             torque_sq_o
);

  logic [wcf_pkg::STAMP_W-1:0]   step;
  logic                          timeout_d;
  logic [2:0][wcf_pkg::SQ_W-1:0] force_sq_d;
  logic [2:0][wcf_pkg::SQ_W-1:0] torque_sq_d;

  wcf_pkg::item_ctl_t            ctl_q;
  wcf_pkg::sample_t              cur_q;
  logic                          timeout_q;
  logic [2:0][wcf_pkg::SQ_W-1:0] force_sq_q;
  logic [2:0][wcf_pkg::SQ_W-1:0] torque_sq_q;

  // Magnitude of the difference of two signed components.
  function automatic logic [wcf_pkg::MAG_W-1:0] abs_diff(
    input logic [wcf_pkg::COMP_W-1:0] a,
    input logic [wcf_pkg::COMP_W-1:0] b
  );
    logic [wcf_pkg::COMP_W:0] d;
    d = {a[wcf_pkg::COMP_W-1], a} - {b[wcf_pkg::COMP_W-1], b};
    if (d[wcf_pkg::COMP_W]) begin
      return wcf_pkg::MAG_W'(~d + 1'b1);
    end
    return d[wcf_pkg::MAG_W-1:0];
  endfunction

  // Time check: a backward step or one beyond a nonzero window.
  always_comb begin
    step      = cur_i.stamp - last_i.stamp;
    timeout_d = (window_i != '0) &&
                ((cur_i.stamp < last_i.stamp) ||
                 (step > wcf_pkg::STAMP_W'(window_i)));
  end

  // Six independent squares, one per component lane.
  always_comb begin
    logic [wcf_pkg::MAG_W-1:0] fm;
    logic [wcf_pkg::MAG_W-1:0] tm;
    for (int i = 0; i < 3; i++) begin
      fm = abs_diff(cur_i.force_vec[i], last_i.force_vec[i]);
      tm = abs_diff(cur_i.torque_vec[i], last_i.torque_vec[i]);
      force_sq_d[i]  = wcf_pkg::SQ_W'(fm) * wcf_pkg::SQ_W'(fm);
      torque_sq_d[i] = wcf_pkg::SQ_W'(tm) * wcf_pkg::SQ_W'(tm);
    end
  end

  // Stage register.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ctl_q       <= ctl_i;
      cur_q       <= cur_i;
      timeout_q   <= timeout_d;
      force_sq_q  <= force_sq_d;
      torque_sq_q <= torque_sq_d;
    end
  end

  assign ctl_o       = ctl_q;
  assign cur_o       = cur_q;
  assign timeout_o   = timeout_q;
  assign force_sq_o  = force_sq_q;
  assign torque_sq_o = torque_sq_q;

endmodule

### src/wcf_decide.sv
// ----------------------------------------------------------------------------
// wcf_decide
// Sums the squared changes, compares them with the squared limits, picks
// the judgement and holds the result for the output channel.
// ----------------------------------------------------------------------------
module wcf_decide (
  input  logic                             clk_i,
  input  logic                             load_i,
  input  wcf_pkg::item_ctl_t               ctl_i,
  input  logic                             timeout_i,
  input  logic [2:0][wcf_pkg::SQ_W-1:0]    force_sq_i,
  input  logic [2:0][wcf_pkg::SQ_W-1:0]    torque_sq_i,
  input  logic [wcf_pkg::LIMSQ_W-1:0]      force_lim_sq_i,
  input  logic [wcf_pkg::LIMSQ_W-1:0]      torque_lim_sq_i,
  output logic                             upd_o,
  output wcf_pkg::result_t                 res_o
);

  logic [wcf_pkg::SUM_W-1:0] force_sum;
  logic [wcf_pkg::SUM_W-1:0] torque_sum;
  logic                      force_over;
  logic                      torque_over;
  wcf_pkg::decision_e        dec;
  logic                      keep;
  wcf_pkg::result_t          res_d;
  wcf_pkg::result_t          res_q;

  // Exact sums of squares against the squared thresholds.
  always_comb begin
    force_sum   = wcf_pkg::SUM_W'(force_sq_i[0]) + wcf_pkg::SUM_W'(force_sq_i[1]) +
                  wcf_pkg::SUM_W'(force_sq_i[2]);
    torque_sum  = wcf_pkg::SUM_W'(torque_sq_i[0]) + wcf_pkg::SUM_W'(torque_sq_i[1]) +
                  wcf_pkg::SUM_W'(torque_sq_i[2]);
    force_over  = force_sum > wcf_pkg::SUM_W'(force_lim_sq_i);
    torque_over = torque_sum > wcf_pkg::SUM_W'(torque_lim_sq_i);
  end

  // Judgement in priority order. A frame without a table entry counts as new.
  always_comb begin
    if (!ctl_i.in_range || !ctl_i.known) begin
      dec = wcf_pkg::DEC_NEW_FRAME;
    end else if (ctl_i.managed) begin
      dec = wcf_pkg::DEC_MANAGED;
    end else if (timeout_i) begin
      dec = wcf_pkg::DEC_TIMEOUT;
    end else if (force_over) begin
      dec = wcf_pkg::DEC_FORCE;
    end else if (torque_over) begin
      dec = wcf_pkg::DEC_TORQUE;
    end else begin
      dec = wcf_pkg::DEC_UNCHANGED;
    end
    keep  = (dec != wcf_pkg::DEC_MANAGED) && (dec != wcf_pkg::DEC_UNCHANGED);
    upd_o = keep && !ctl_i.managed && ctl_i.in_range;

    res_d.frame      = ctl_i.frame;
    res_d.decision   = dec;
    res_d.log_sample = keep;
    res_d.mem_upd    = upd_o;
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
